### src/dsuvg_pkg.sv
// ----------------------------------------------------------------------------
// dsuvg_pkg
// Shared types, register indexes and constants of the drift-scan uv gridder.
// ----------------------------------------------------------------------------
package dsuvg_pkg;

  // Configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_IW-1:0] CFG_SIN_LAT     = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_COS_LAT     = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_BIN_SCALE   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_FIRST_ANGLE = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_ANGLE_STEP  = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_TIME_STEP   = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_STEP_COUNT  = 3'd6;

  // Item kinds
  localparam logic OP_DEPOSIT = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // Largest number of hour-angle samples per baseline
  localparam logic [10:0] STEP_MAX = 11'd1024;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // CORDIC start gain in Q.30
  localparam logic signed [32:0] CORDIC_X0 = 33'sh026DD3B6A;

  typedef struct packed {
    logic [15:0] sin_lat;
    logic [15:0] cos_lat;
    logic [31:0] bin_scale;
    logic [15:0] first_angle;
    logic [15:0] angle_step;
    logic [31:0] time_step;
    logic [10:0] step_count;
  } cfg_t;

  // One queued item: kind, read cell and the rotated baseline terms
  typedef struct packed {
    logic        op;
    logic [5:0]  read_u;
    logic [5:0]  read_v;
    logic [35:0] bx;
    logic [35:0] by;
    logic [35:0] bz;
    logic [47:0] mt;
  } qent_t;

  // Arctangent of 2^-i in turns scaled to 2^32
  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    case (idx)
      5'd0:    return 30'h20000000;
      5'd1:    return 30'h12E4051E;
      5'd2:    return 30'h09FB385B;
      5'd3:    return 30'h051111D4;
      5'd4:    return 30'h028B0D43;
      5'd5:    return 30'h0145D7E1;
      5'd6:    return 30'h00A2F61E;
      5'd7:    return 30'h00517C55;
      5'd8:    return 30'h0028BE53;
      5'd9:    return 30'h00145F2F;
      5'd10:   return 30'h000A2F98;
      5'd11:   return 30'h000517CC;
      5'd12:   return 30'h00028BE6;
      5'd13:   return 30'h000145F3;
      5'd14:   return 30'h0000A2FA;
      5'd15:   return 30'h0000517D;
      5'd16:   return 30'h000028BE;
      5'd17:   return 30'h0000145F;
      5'd18:   return 30'h00000A30;
      5'd19:   return 30'h00000518;
      5'd20:   return 30'h0000028C;
      5'd21:   return 30'h00000146;
      5'd22:   return 30'h000000A3;
      5'd23:   return 30'h00000051;
      default: return 30'h00000000;
    endcase
  endfunction

endpackage

### src/dsuvg_ram.sv
// ----------------------------------------------------------------------------
// dsuvg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsuvg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/dsuvg_queue.sv
// ----------------------------------------------------------------------------
// dsuvg_queue
// Short in-order queue of classified items between front and back.
// ----------------------------------------------------------------------------
module dsuvg_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dsuvg_pkg::qent_t wdata,
  output logic             full,
  input  logic             pop,
  output dsuvg_pkg::qent_t rdata,
  output logic             empty
);
  import dsuvg_pkg::*;

  qent_t          slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign full  = (count_r == (QAW+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign rdata = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### src/dsuvg_cordic.sv
// ----------------------------------------------------------------------------
// dsuvg_cordic
// Iterative rotation CORDIC: one step per cycle, gives sin and cos in Q.16.
// ----------------------------------------------------------------------------
module dsuvg_cordic #(
  parameter int CORDIC_ITERS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               done,
  output logic signed [17:0] sin_o,
  output logic signed [17:0] cos_o
);
  import dsuvg_pkg::*;

  localparam int IW = $clog2(CORDIC_ITERS);
  localparam logic [IW-1:0] LAST_IT = IW'(CORDIC_ITERS - 1);

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  logic                run_r, fin_r, done_r;
  logic [IW-1:0]       it_r;
  logic signed [32:0]  x_r, y_r, z_r;
  logic [1:0]          quad_r;
  logic signed [17:0]  sin_r, cos_r;
  logic signed [32:0]  dx, dy, at;
  logic signed [32:0]  sq, cq;

  // Round half up to Q.16 and clamp to one
  function automatic logic signed [17:0] clamp16(input logic signed [32:0] v);
    logic signed [33:0] t;
    logic signed [19:0] r;
    t = 34'(v) + 34'sd8192;
    r = 20'(t >>> 14);
    if (r > 20'sd65536) begin
      return 18'sd65536;
    end else if (r < -20'sd65536) begin
      return -18'sd65536;
    end
    return 18'(r);
  endfunction

  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;
  assign at = $signed(33'(atan_lut(5'(it_r))));

  // Fold the quadrant back in
  always_comb begin
    case (quad_r)
      QUAD_I: begin
        cq = x_r;
        sq = y_r;
      end
      QUAD_II: begin
        cq = -y_r;
        sq = x_r;
      end
      QUAD_III: begin
        cq = -x_r;
        sq = -y_r;
      end
      default: begin
        cq = y_r;
        sq = -x_r;
      end
    endcase
  end

  // Sequence start, iterations and finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= run_r && (it_r == LAST_IT);
      if (start) begin
        run_r <= 1'b1;
        it_r  <= '0;
      end else if (run_r) begin
        if (it_r == LAST_IT) begin
          run_r <= 1'b0;
        end
        it_r <= it_r + 1'b1;
      end
    end
  end

  // Rotate one step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_X0;
      y_r    <= '0;
      z_r    <= $signed(33'({angle[13:0], 16'h0000}));
      quad_r <= angle[15:14];
    end else if (run_r) begin
      if (!z_r[32]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
    if (fin_r) begin
      sin_r <= clamp16(sq);
      cos_r <= clamp16(cq);
    end
  end

  assign done  = done_r;
  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

### src/dsuvg_front.sv
// ----------------------------------------------------------------------------
// dsuvg_front
// Accept items, classify them and form the latitude-rotated baseline terms.
// ----------------------------------------------------------------------------
module dsuvg_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             hold,
  input  dsuvg_pkg::cfg_t  cfg,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [71:0]      in_tdata,
  input  logic             in_tuser,
  output logic             q_push,
  output dsuvg_pkg::qent_t q_wdata,
  input  logic             q_full
);
  import dsuvg_pkg::*;

  logic               s1_v_r, s1_v_nxt;
  logic               s1_op_r;
  logic [19:0]        s1_x_r, s1_y_r;
  logic [15:0]        s1_mult_r;
  logic [5:0]         s1_ru_r, s1_rv_r;
  logic               accept;
  logic signed [35:0] ysl, ycl, xsh;

  assign in_tready = !hold && (!s1_v_r || !q_full);
  assign accept    = in_tvalid && in_tready;
  assign q_push    = s1_v_r && !q_full;

  // Hold one item until the queue takes it
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (q_push) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= in_tuser;
      s1_x_r    <= in_tdata[19:0];
      s1_y_r    <= in_tdata[39:20];
      s1_mult_r <= in_tdata[55:40];
      s1_ru_r   <= in_tdata[61:56];
      s1_rv_r   <= in_tdata[67:62];
    end
  end

  // Baseline terms: -y*sl, x*2^15, y*cl and multiplicity times step time
  assign ysl = 36'($signed(s1_y_r)) * 36'($signed(cfg.sin_lat));
  assign ycl = 36'($signed(s1_y_r)) * 36'($signed(cfg.cos_lat));
  assign xsh = 36'($signed(s1_x_r)) <<< 15;

  always_comb begin
    q_wdata.op     = s1_op_r;
    q_wdata.read_u = s1_ru_r;
    q_wdata.read_v = s1_rv_r;
    q_wdata.bx     = unsigned'(-ysl);
    q_wdata.by     = unsigned'(xsh);
    q_wdata.bz     = unsigned'(ycl);
    q_wdata.mt     = 48'(s1_mult_r) * 48'(cfg.time_step);
  end

endmodule

### src/dsuvg_back.sv
// ----------------------------------------------------------------------------
// dsuvg_back
// Clear the grid, answer cell reads and run the per-sample deposit sequence.
// ----------------------------------------------------------------------------
module dsuvg_back #(
  parameter int GRID_U       = 64,
  parameter int GRID_V       = 64,
  parameter int CORDIC_ITERS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dsuvg_pkg::cfg_t  cfg,
  input  logic             q_empty,
  input  dsuvg_pkg::qent_t q_rdata,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,
  output logic             clearing
);
  import dsuvg_pkg::*;

  localparam int DEPTH = GRID_U * GRID_V;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic signed [53:0] CTR_U = 54'((GRID_U / 2) * 65536);
  localparam logic signed [53:0] CTR_V = 54'((GRID_V / 2) * 65536);

  typedef enum logic [15:0] {
    ST_CLEAR     = 16'h0001,
    ST_IDLE      = 16'h0002,
    ST_RD_OUT    = 16'h0004,
    ST_CORD_GO   = 16'h0008,
    ST_CORD_WAIT = 16'h0010,
    ST_MUL_A     = 16'h0020,
    ST_SUM_A     = 16'h0040,
    ST_MUL_B     = 16'h0080,
    ST_SUM_B     = 16'h0100,
    ST_BIN_MUL   = 16'h0200,
    ST_BIN_SUM   = 16'h0400,
    ST_AMT_A     = 16'h0800,
    ST_AMT_B     = 16'h1000,
    ST_DEP_RD    = 16'h2000,
    ST_DEP_WR    = 16'h4000,
    ST_NEXT      = 16'h8000
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [47:0]        out_data_r, out_data_nxt;
  logic [10:0]        k_r, k_nxt;
  logic [1:0]         cn_r, cn_nxt;

  logic signed [35:0] bx_r, by_r, bz_r;
  logic [47:0]        mt_r;
  logic [10:0]        n_r, n_sel;
  logic [15:0]        ang_r;
  logic signed [53:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [38:0] ku_r, pp_r;
  logic signed [55:0] q1_r, q2_r;
  logic signed [40:0] kv_r;
  logic [57:0]        mh_r, ml_r;
  logic               neg_r;
  logic signed [53:0] pu_r, pv_r;
  logic [47:0]        au_r [2];
  logic [47:0]        amt_r [4];

  logic               cord_start, cord_done;
  logic signed [17:0] cord_sin, cord_cos;
  logic signed [41:0] kue, kve;
  logic [41:0]        mag_u, mag_v, bin_mag;
  logic [58:0]        bin_sum;
  logic signed [53:0] pos_s;
  logic [16:0]        wu0, wu1, wv0, wv1;
  logic signed [38:0] cu, cv;
  logic               corner_ok, rd_ok;
  logic [AW-1:0]      dep_addr, rd_addr;
  logic [48:0]        sum49;
  logic [47:0]        sat_sum;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [47:0]        ram_wdata, ram_rdata;

  dsuvg_cordic #(.CORDIC_ITERS(CORDIC_ITERS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .angle (ang_r),
    .done  (cord_done),
    .sin_o (cord_sin),
    .cos_o (cord_cos)
  );

  dsuvg_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign n_sel = (cfg.step_count > STEP_MAX) ? STEP_MAX : cfg.step_count;

  // Magnitudes for the bin scaling; one multiplier pair serves u then v
  assign kue     = 42'(ku_r);
  assign kve     = 42'(kv_r);
  assign mag_u   = kue[41] ? unsigned'(-kue) : unsigned'(kue);
  assign mag_v   = kve[41] ? unsigned'(-kve) : unsigned'(kve);
  assign bin_mag = (state_r == ST_BIN_MUL) ? mag_v : mag_u;

  // Bin position: magnitude truncated, sign restored, grid center added
  assign bin_sum = 59'(mh_r) + 59'(ml_r[57:16]);
  always_comb begin
    pos_s = $signed(54'(bin_sum[58:7]));
    if (neg_r) begin
      pos_s = -pos_s;
    end
    pos_s = pos_s + ((state_r == ST_SUM_B) ? CTR_U : CTR_V);
  end

  // Bilinear weights
  assign wu1 = {1'b0, pu_r[15:0]};
  assign wu0 = 17'h10000 - wu1;
  assign wv1 = {1'b0, pv_r[15:0]};
  assign wv0 = 17'h10000 - wv1;

  // Corner of the current deposit and its grid address
  assign cu = 39'($signed(pu_r[53:16])) + 39'({1'b0, cn_r[1]});
  assign cv = 39'($signed(pv_r[53:16])) + 39'({1'b0, cn_r[0]});
  assign corner_ok = !cu[38] && (cu[37:0] < 38'(GRID_U)) &&
                     !cv[38] && (cv[37:0] < 38'(GRID_V));
  assign dep_addr = cu[AW-1:0] * AW'(GRID_V) + cv[AW-1:0];

  assign rd_ok   = (32'(q_rdata.read_u) < GRID_U) && (32'(q_rdata.read_v) < GRID_V);
  assign rd_addr = AW'(q_rdata.read_u) * AW'(GRID_V) + AW'(q_rdata.read_v);

  // Saturating accumulate
  assign sum49   = 49'(ram_rdata) + 49'(amt_r[cn_r]);
  assign sat_sum = sum49[48] ? '1 : sum49[47:0];

  // Sequence control
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    k_nxt         = k_r;
    cn_nxt        = cn_r;
    q_pop         = 1'b0;
    cord_start    = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = dep_addr;
    ram_wdata     = sat_sum;
    ram_raddr     = dep_addr;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        ram_raddr = rd_addr;
        if (!q_empty) begin
          if (q_rdata.op == OP_READ) begin
            if (!out_valid_r) begin
              q_pop = 1'b1;
              if (rd_ok) begin
                state_nxt = ST_RD_OUT;
              end else begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '0;
              end
            end
          end else begin
            q_pop = 1'b1;
            k_nxt = '0;
            if (n_sel != '0) begin
              state_nxt = ST_CORD_GO;
            end
          end
        end
      end
      ST_RD_OUT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = ram_rdata;
        state_nxt     = ST_IDLE;
      end
      ST_CORD_GO: begin
        cord_start = 1'b1;
        state_nxt  = ST_CORD_WAIT;
      end
      ST_CORD_WAIT: begin
        if (cord_done) begin
          state_nxt = ST_MUL_A;
        end
      end
      ST_MUL_A:   state_nxt = ST_SUM_A;
      ST_SUM_A:   state_nxt = ST_MUL_B;
      ST_MUL_B:   state_nxt = ST_SUM_B;
      ST_SUM_B:   state_nxt = ST_BIN_MUL;
      ST_BIN_MUL: state_nxt = ST_BIN_SUM;
      ST_BIN_SUM: state_nxt = ST_AMT_A;
      ST_AMT_A:   state_nxt = ST_AMT_B;
      ST_AMT_B: begin
        cn_nxt    = '0;
        state_nxt = ST_DEP_RD;
      end
      ST_DEP_RD:  state_nxt = ST_DEP_WR;
      ST_DEP_WR: begin
        ram_we = corner_ok;
        if (cn_r == 2'd3) begin
          state_nxt = ST_NEXT;
        end else begin
          cn_nxt    = cn_r + 1'b1;
          state_nxt = ST_DEP_RD;
        end
      end
      ST_NEXT: begin
        k_nxt = k_r + 1'b1;
        if (k_r + 11'd1 == n_r) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_CORD_GO;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      cn_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      cn_r        <= cn_nxt;
    end
  end

  // Datapath: one multiply or one add stage per state
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    case (state_r)
      ST_IDLE: begin
        if (q_pop && (q_rdata.op == OP_DEPOSIT)) begin
          bx_r  <= $signed(q_rdata.bx);
          by_r  <= $signed(q_rdata.by);
          bz_r  <= $signed(q_rdata.bz);
          mt_r  <= q_rdata.mt;
          n_r   <= n_sel;
          ang_r <= cfg.first_angle;
        end
      end
      ST_MUL_A: begin
        p1_r <= 54'(bx_r) * 54'(cord_sin);
        p2_r <= 54'(by_r) * 54'(cord_cos);
        p3_r <= 54'(by_r) * 54'(cord_sin);
        p4_r <= 54'(bx_r) * 54'(cord_cos);
      end
      ST_SUM_A: begin
        ku_r <= 39'((p1_r + p2_r) >>> 16);
        pp_r <= 39'((p3_r - p4_r) >>> 16);
      end
      ST_MUL_B: begin
        q1_r  <= 56'(pp_r) * 56'($signed(cfg.sin_lat));
        q2_r  <= 56'(bz_r) * 56'($signed(cfg.cos_lat));
        mh_r  <= 58'(bin_mag) * 58'(cfg.bin_scale[31:16]);
        ml_r  <= 58'(bin_mag) * 58'(cfg.bin_scale[15:0]);
        neg_r <= ku_r[38];
      end
      ST_SUM_B: begin
        kv_r <= 41'((q1_r + q2_r) >>> 15);
        pu_r <= pos_s;
      end
      ST_BIN_MUL: begin
        mh_r  <= 58'(bin_mag) * 58'(cfg.bin_scale[31:16]);
        ml_r  <= 58'(bin_mag) * 58'(cfg.bin_scale[15:0]);
        neg_r <= kv_r[40];
      end
      ST_BIN_SUM: begin
        pv_r <= pos_s;
      end
      ST_AMT_A: begin
        au_r[0] <= 48'((65'(mt_r) * 65'(wu0)) >> 16);
        au_r[1] <= 48'((65'(mt_r) * 65'(wu1)) >> 16);
      end
      ST_AMT_B: begin
        amt_r[0] <= 48'((65'(au_r[0]) * 65'(wv0)) >> 16);
        amt_r[1] <= 48'((65'(au_r[0]) * 65'(wv1)) >> 16);
        amt_r[2] <= 48'((65'(au_r[1]) * 65'(wv0)) >> 16);
        amt_r[3] <= 48'((65'(au_r[1]) * 65'(wv1)) >> 16);
      end
      ST_NEXT: begin
        ang_r <= ang_r + cfg.angle_step;
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign clearing   = (state_r == ST_CLEAR);

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_rdata.op == OP_READ)) |-> !out_valid_r)
    else $error("read taken while a result is still pending");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !q_pop)
    else $error("item taken during grid clear");

  a_cordic_expected: assert property (@(posedge clk) disable iff (!rst_n)
    cord_done |-> (state_r == ST_CORD_WAIT))
    else $error("CORDIC finished outside its wait state");
`endif

endmodule

### src/drift_scan_uv_gridder_unit.sv
// ----------------------------------------------------------------------------
// drift_scan_uv_gridder_unit
// Top level of the drift-scan uv observation-time gridder.
// ----------------------------------------------------------------------------
// After reset the block sweeps the grid to zero, one cell per cycle; no item
// is taken until that is done, while configuration writes are taken at any
// time. A read item at the head of the queue waits until no result is
// pending; its cell is then read through the registered grid RAM read port
// and registered onto the output. A deposit item leaves the queue and then
// occupies the back end for step_count samples: each sample runs the
// iterative CORDIC one step per cycle, then a chain of registered multiply
// and add stages, then four read-modify-write passes on the single grid RAM.
// Up to five items wait in the front stage and queue while the back end is
// busy.
module drift_scan_uv_gridder_unit #(
  parameter int GRID_U       = 64,
  parameter int GRID_V       = 64,
  parameter int CORDIC_ITERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // east_offset[19:0], north_offset[39:20], multiplicity[55:40],
  // read_u[61:56], read_v[67:62], zero pad[71:68]
  input  logic [71:0] in_tdata,
  // op[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cell_value[47:0]
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import dsuvg_pkg::*;

  cfg_t  cfg_r;
  logic  q_push, q_pop, q_full, q_empty, clearing;
  qent_t q_wdata, q_rdata;

  // Register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sin_lat     <= 16'h0000;
      cfg_r.cos_lat     <= 16'h7FFF;
      cfg_r.bin_scale   <= 32'h0;
      cfg_r.first_angle <= 16'h0;
      cfg_r.angle_step  <= 16'h0;
      cfg_r.time_step   <= 32'h0;
      cfg_r.step_count  <= 11'd101;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIN_LAT:     cfg_r.sin_lat     <= cfg_wdata[15:0];
        CFG_COS_LAT:     cfg_r.cos_lat     <= cfg_wdata[15:0];
        CFG_BIN_SCALE:   cfg_r.bin_scale   <= cfg_wdata;
        CFG_FIRST_ANGLE: cfg_r.first_angle <= cfg_wdata[15:0];
        CFG_ANGLE_STEP:  cfg_r.angle_step  <= cfg_wdata[15:0];
        CFG_TIME_STEP:   cfg_r.time_step   <= cfg_wdata;
        CFG_STEP_COUNT:  cfg_r.step_count  <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  dsuvg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (clearing),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .q_full    (q_full)
  );

  dsuvg_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  dsuvg_back #(
    .GRID_U       (GRID_U),
    .GRID_V       (GRID_V),
    .CORDIC_ITERS (CORDIC_ITERS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .clearing   (clearing)
  );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the drift-scan uv gridder. An in-bench grid model
// predicts every cell read. Deposits and reads are streamed with random
// gaps and output stalls over several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
  import dsuvg_pkg::*;

  typedef struct {
    logic               op;
    logic signed [19:0] east;
    logic signed [19:0] north;
    logic [15:0]        mult;
    logic [5:0]         ru;
    logic [5:0]         rv;
  } job_t;

  // Register index with no register behind it
  localparam logic [2:0] CFG_NO_REG = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  drift_scan_uv_gridder_unit DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state and register copies
  logic [47:0]        cell_acc [4096];
  logic signed [15:0] lat_sin = 16'sd0, lat_cos = 16'sd32767;
  logic [31:0]        scale_q = '0, tstep_q = '0;
  logic [15:0]        angle0_q = '0, dangle_q = '0;
  logic [10:0]        nsteps_q = 11'd101;

  job_t        job_q[$];
  job_t        cur_job;
  logic [47:0] cell_exp_q[$];
  logic        in_acc = 1'b0;
  logic        quiet = 1'b0;
  int          errs = 0;
  int          in_gap = 0, out_gap = 0;

  const longint atan_turn[16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

  function automatic longint round_clamp(input longint v);
    longint r;
    r = (v + 64'sd8192) >>> 14;
    if (r > 64'sd65536) r = 64'sd65536;
    if (r < -64'sd65536) r = -64'sd65536;
    return r;
  endfunction

  // Quadrant fold plus 16-step rotation CORDIC
  function automatic void hour_sincos(input logic [15:0] a, output longint s,
                                      output longint c);
    longint x, y, z, dx, dy, cs, sn;
    x = 64'h26DD3B6A;
    y = 0;
    z = longint'(a[13:0]) <<< 16;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_turn[i];
      end else begin
        x += dx; y -= dy; z += atan_turn[i];
      end
    end
    case (a[15:14])
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
    s = round_clamp(sn);
    c = round_clamp(cs);
  endfunction

  function automatic longint scale_bins(input longint k, input logic [31:0] b);
    logic [63:0] mag, r;
    mag = (k < 0) ? 64'(-k) : 64'(k);
    r = (mag * b[31:16] + ((mag * b[15:0]) >> 16)) >> 7;
    return (k < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void bump_cell(input longint u, input longint v,
                                    input logic [63:0] amt);
    logic [63:0] sum;
    if (u < 0 || u > 63 || v < 0 || v > 63) return;
    sum = cell_acc[u*64+v] + amt;
    cell_acc[u*64+v] = (sum > 64'hFFFFFFFFFFFF) ? 48'hFFFFFFFFFFFF : sum[47:0];
  endfunction

  // Sweep one baseline through all hour-angle samples
  function automatic void deposit_baseline(input job_t j);
    longint x, y, bx, by, bz, s, c, ku, p, kv, pu, pv, ub, vb;
    logic [63:0] mt, wu[2], wv[2];
    logic [15:0] ang;
    int n;
    x = j.east;
    y = j.north;
    mt = 64'(j.mult) * 64'(tstep_q);
    bx = -(y * lat_sin);
    by = x * 32768;
    bz = y * lat_cos;
    n = (nsteps_q > 11'd1024) ? 1024 : int'(nsteps_q);
    ang = angle0_q;
    for (int k = 0; k < n; k++) begin
      hour_sincos(ang, s, c);
      ku = (bx * s + by * c) >>> 16;
      p  = (by * s - bx * c) >>> 16;
      kv = (p * lat_sin + bz * lat_cos) >>> 15;
      pu = scale_bins(ku, scale_q) + 32 * 65536;
      pv = scale_bins(kv, scale_q) + 32 * 65536;
      ub = pu >>> 16;
      vb = pv >>> 16;
      wu[1] = 64'(pu[15:0]); wu[0] = 65536 - wu[1];
      wv[1] = 64'(pv[15:0]); wv[0] = 65536 - wv[1];
      for (int i = 0; i < 2; i++)
        for (int m = 0; m < 2; m++)
          bump_cell(ub + i, vb + m, (((mt * wu[i]) >> 16) * wv[m]) >> 16);
      ang = ang + dangle_q;
    end
  endfunction

  // Record input transfers and update the grid model
  always @(posedge clk) begin
    in_acc <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      if (cur_job.op == OP_READ) begin
        cell_exp_q.insert(cell_exp_q.size(), cell_acc[cur_job.ru*64+cur_job.rv]);
      end else begin
        deposit_baseline(cur_job);
      end
    end
  end

  // Check each result transfer against the oldest expected cell
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (cell_exp_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, out_tdata);
        errs++;
      end else begin
        if (out_tdata !== cell_exp_q[0]) begin
          $display("%0t cell_value mismatch: expected %h, actual %h",
                   $time, cell_exp_q[0], out_tdata);
          errs++;
        end
        void'(cell_exp_q.pop_front());
      end
    end
  end

  // Sender: hold each item until its transfer, insert gap bursts
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_acc)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (job_q.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(0, 6);
        in_tvalid <= 1'b0;
      end else if (job_q.size() != 0) begin
        cur_job = job_q.pop_front();
        in_tdata <= {4'b0, cur_job.rv, cur_job.ru, cur_job.mult,
                     cur_job.north, cur_job.east};
        in_tuser <= cur_job.op;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall in bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_gap <= $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      CFG_SIN_LAT:     lat_sin = val[15:0];
      CFG_COS_LAT:     lat_cos = val[15:0];
      CFG_BIN_SCALE:   scale_q = val;
      CFG_FIRST_ANGLE: angle0_q = val[15:0];
      CFG_ANGLE_STEP:  dangle_q = val[15:0];
      CFG_TIME_STEP:   tstep_q = val;
      CFG_STEP_COUNT:  nsteps_q = val[10:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_regs(input logic [15:0] sl, input logic [15:0] cl,
                           input logic [31:0] bs, input logic [15:0] fa,
                           input logic [15:0] da, input logic [31:0] ts,
                           input logic [10:0] sc);
    write_reg(CFG_SIN_LAT, {$urandom} & 32'hFFFF0000 | 32'(sl));
    write_reg(CFG_COS_LAT, 32'(cl));
    write_reg(CFG_BIN_SCALE, bs);
    write_reg(CFG_FIRST_ANGLE, 32'(fa));
    write_reg(CFG_ANGLE_STEP, 32'(da));
    write_reg(CFG_TIME_STEP, ts);
    write_reg(CFG_STEP_COUNT, 32'(sc));
  endtask

  task automatic add_job(input logic op, input logic [19:0] e, input logic [19:0] n,
                         input logic [15:0] m, input logic [5:0] u, input logic [5:0] v);
    job_t j;
    j.op = op; j.east = e; j.north = n; j.mult = m; j.ru = u; j.rv = v;
    job_q.insert(job_q.size(), j);
  endtask

  task automatic add_random(input int count);
    logic [19:0] e, n;
    logic [5:0] u, v;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        e = 20'($urandom); n = 20'($urandom);
      end else begin
        e = 20'($urandom_range(0, 8191) - 4096);
        n = 20'($urandom_range(0, 8191) - 4096);
      end
      if ($urandom_range(0, 1)) begin
        u = 6'($urandom_range(20, 44)); v = 6'($urandom_range(20, 44));
      end else begin
        u = 6'($urandom); v = 6'($urandom);
      end
      add_job($urandom_range(0, 9) < 6 ? OP_DEPOSIT : OP_READ, e, n,
              16'($urandom_range(1, 65535)), u, v);
    end
  endtask

  // Finish a phase with a read, then wait for the grid to go idle
  task automatic drain;
    add_job(OP_READ, 20'($urandom), 20'($urandom), 16'($urandom), 6'd32, 6'd32);
    while (job_q.size() != 0 || in_tvalid || cell_exp_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < 4096; i++) cell_acc[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, both ops, grid corners
    load_regs(16'd0, 16'd32767, 32'h00040000, 16'h0000, 16'h1000, 32'h00010000, 11'd4);
    add_job(OP_DEPOSIT, 20'h7FFFF, 20'h7FFFF, 16'd1, 6'd0, 6'd0);
    add_job(OP_DEPOSIT, 20'h80000, 20'h80000, 16'hFFFF, 6'h3F, 6'h3F);
    add_job(OP_DEPOSIT, 20'd600, 20'hFFE00, 16'd7, 6'd0, 6'd0);
    add_job(OP_DEPOSIT, 20'd0, 20'd0, 16'h5555, 6'd0, 6'd0);
    add_job(OP_READ, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 6'd0, 6'd0);
    add_job(OP_READ, 20'd0, 20'd0, 16'd0, 6'h3F, 6'h3F);
    add_job(OP_READ, 20'd0, 20'd0, 16'd0, 6'd31, 6'd32);
    add_job(OP_READ, 20'd0, 20'd0, 16'd0, 6'd33, 6'd31);
    drain();

    // Accumulator saturation at the grid center
    load_regs(16'h8000, 16'h8000, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 11'd2);
    add_job(OP_DEPOSIT, 20'd0, 20'd0, 16'hFFFF, 6'd0, 6'd0);
    add_job(OP_DEPOSIT, 20'd0, 20'd0, 16'hFFFF, 6'd0, 6'd0);
    add_job(OP_READ, 20'd0, 20'd0, 16'd0, 6'd32, 6'd32);
    add_job(OP_DEPOSIT, 20'd3000, 20'h80000, 16'hFFFF, 6'd0, 6'd0);
    drain();

    // Zero samples, then a step count above the maximum, then a bad index
    write_reg(CFG_STEP_COUNT, 32'd0);
    add_job(OP_DEPOSIT, 20'd100, 20'd50, 16'd9, 6'd0, 6'd0);
    drain();
    load_regs(16'd23170, 16'd23170, 32'h00020000, 16'h4000, 16'h0040, 32'h00008000, 11'h7FF);
    add_job(OP_DEPOSIT, 20'd2000, 20'hFF000, 16'd3, 6'd0, 6'd0);
    add_job(OP_READ, 20'd0, 20'd0, 16'd0, 6'd28, 6'd35);
    drain();
    write_reg(CFG_NO_REG, 32'hFFFFFFFF);

    // Random phases with fresh register settings
    for (int ph = 0; ph < 11; ph++) begin
      if (ph == 10) quiet = 1'b1;
      load_regs(16'($urandom), 16'($urandom),
                ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1 << 14, 1 << 20),
                16'($urandom), 16'($urandom), $urandom, 11'($urandom_range(1, 5)));
      add_random(105);
      drain();
    end

    if (errs == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #60000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
src/dsuvg_pkg.sv
src/dsuvg_ram.sv
src/dsuvg_queue.sv
src/dsuvg_cordic.sv
src/dsuvg_front.sv
src/dsuvg_back.sv
src/drift_scan_uv_gridder_unit.sv
tb/sv/tb_top.sv
